// ----- src/lru_page_frame_manager_macros.svh -----
`ifndef LRU_PAGE_FRAME_MANAGER_MACROS_SVH
`define LRU_PAGE_FRAME_MANAGER_MACROS_SVH

// implication checked on every clock edge out of reset
`define LPFM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpfm check failed");

// implication checked on the edge after the antecedent
`define LPFM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpfm check failed");

`endif

// ----- src/lpfm_pkg.sv -----
`default_nettype none
package lpfm_pkg;

	localparam int PAGE_IDS_DEF = 1024;
	localparam int FRAMES_DEF   = 32;
	localparam logic [16:0] PAGE_SIZE_RST = 17'd4096;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		MODE_ACCESS   = 3'd0,
		MODE_PREALLOC = 3'd1,
		MODE_TOUCH    = 3'd2,
		MODE_ERASE    = 3'd3,
		MODE_WBPAGE   = 3'd4,
		MODE_FLUSH    = 3'd5
	} mode_e;

	typedef struct packed {
		logic [2:0]  mode;
		logic [9:0]  page_id;
		logic [15:0] offset;
		logic [16:0] length;
	} req_t;

	typedef struct packed {
		logic        status;
		logic        hit;
		logic [4:0]  frame;
		logic        fill_from_storage;
		logic        writeback;
		logic [9:0]  writeback_page;
		logic [4:0]  writeback_frame;
		logic [16:0] transfer_length;
		logic        last;
	} rsp_t;

	// classified command handed from front to back
	typedef struct packed {
		mode_e       mode;
		logic [9:0]  page_id;
		logic [16:0] xfer;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t data;
	} front_push_t;

	typedef struct packed {
		logic full;
		logic clearing;
	} back_stat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_UNLINK,
		ST_APPEND,
		ST_EVICT,
		ST_ALLOC,
		ST_RELEASE,
		ST_SCAN,
		ST_SCHK
	} back_state_t;

endpackage
`default_nettype wire

// ----- src/lru_page_frame_manager.sv -----
// a request passes the queue, then the back-end states IDLE and LOOK; touch, erase or write-back
// of a page not resident answers from LOOK, erase or write-back of a resident page from RELEASE,
// a hit from UNLINK and APPEND, an allocating miss from ALLOC and APPEND, with EVICT before ALLOC
// on eviction; the back end takes the next request only on return to IDLE, and flush runs SCAN
// and SCHK for each page scanned up to the last resident one; busy is high after reset while the
// page map is cleared; results are single-cycle strobes; the receiver cannot stall
`default_nettype none
module lru_page_frame_manager #(
	parameter int PAGE_IDS = lpfm_pkg::PAGE_IDS_DEF,
	parameter int FRAMES   = lpfm_pkg::FRAMES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire lpfm_pkg::req_t req,
	output logic                rsp_valid,
	output lpfm_pkg::rsp_t      rsp,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [16:0]    cfg_data
);
	import lpfm_pkg::*;

	front_push_t push;
	back_stat_t  stat;
	logic        q_valid, q_pop, q_full, clearing;
	cmd_t        q_data;

	assign stat.full     = q_full;
	assign stat.clearing = clearing;

	lpfm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.busy      (busy),
		.push      (push)
	);

	lpfm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (q_pop),
		.full   (q_full),
		.valid  (q_valid),
		.data   (q_data)
	);

	lpfm_back #(.PAGE_IDS(PAGE_IDS), .FRAMES(FRAMES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);
endmodule
`default_nettype wire

// ----- src/lpfm_ram.sv -----
`default_nettype none
module lpfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- src/lpfm_queue.sv -----
`default_nettype none
module lpfm_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lpfm_pkg::front_push_t push,
	input  wire logic                 pop,
	output logic                      full,
	output logic                      valid,
	output lpfm_pkg::cmd_t            data
);
	import lpfm_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          ent_q [QUEUE_DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign do_push = push.push && !full;
	assign do_pop  = pop && valid;
	assign full    = (cnt_q == CW'(QUEUE_DEPTH));
	assign valid   = (cnt_q != '0);
	assign data    = ent_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= push.data;
		end
	end
endmodule
`default_nettype wire

// ----- src/lpfm_front.sv -----
`default_nettype none
module lpfm_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire lpfm_pkg::req_t        req,
	input  wire lpfm_pkg::back_stat_t  stat,
	input  wire logic                  cfg_valid,
	input  wire logic [16:0]           cfg_data,
	output logic                       cfg_ready,
	output logic                       busy,
	output lpfm_pkg::front_push_t      push
);
	import lpfm_pkg::*;

	logic [16:0] page_size_q;
	logic [16:0] room;
	logic [16:0] xfer;
	logic        accept;
	logic        known;

	assign cfg_ready = 1'b1;
	assign busy      = stat.full || stat.clearing;
	assign accept    = start && !busy;

	// modes six and seven give nothing and never reach the back end
	assign known = (req.mode <= 3'(MODE_FLUSH));

	always_comb begin
		room = (page_size_q > {1'b0, req.offset}) ? page_size_q - {1'b0, req.offset} : '0;
		xfer = (req.length < room) ? req.length : room;
	end

	always_comb begin
		push.push         = accept && known;
		push.data.mode    = mode_e'(req.mode);
		push.data.page_id = req.page_id;
		push.data.xfer    = xfer;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= PAGE_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			page_size_q <= cfg_data;
		end
	end
endmodule
`default_nettype wire

// ----- src/lpfm_back.sv -----
`default_nettype none
module lpfm_back #(
	parameter int PAGE_IDS = 1024,
	parameter int FRAMES   = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire lpfm_pkg::cmd_t q_data,
	output logic                q_pop,
	output logic                clearing,
	output logic                rsp_valid,
	output lpfm_pkg::rsp_t      rsp
);
	import lpfm_pkg::*;

	localparam int PW = $clog2(PAGE_IDS);
	localparam int FW = $clog2(FRAMES);
	localparam int CW = FW + 1;

	back_state_t   state_q, state_d;
	cmd_t          cmd_q;
	logic [PW-1:0] scan_q;
	logic [PW-1:0] clr_q;

	logic [PW-1:0] owner_q [FRAMES];
	logic [FW-1:0] next_q  [FRAMES];
	logic [FW-1:0] prev_q  [FRAMES];
	logic [FRAMES-1:0] used_q;
	logic [FW-1:0] head_q, tail_q;
	logic [CW-1:0] ucnt_q;
	logic [FW-1:0] fq_q [FRAMES];
	logic [FW-1:0] fhead_q, ftail_q;
	logic [CW-1:0] fcnt_q;

	logic [FW-1:0] tf_q, vf_q;
	logic [PW-1:0] vp_q;
	logic          wb_q, hit_q;

	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// map memory: frame index per page, validated against owner and used bits
	logic          m_we;
	logic [PW-1:0] m_waddr, m_raddr;
	logic [FW-1:0] m_wdata, m_rdata;

	logic [PW-1:0] cmd_page, cmp_page;
	logic          resident;
	logic [FW-1:0] uf, af, pop_f;
	logic [FW-1:0] ul_n, ul_p;
	logic          do_unlink, do_append, do_push, do_pop, ul_mid;
	logic          emit;
	rsp_t          emit_rsp;

	lpfm_ram #(.WIDTH(FW), .DEPTH(PAGE_IDS)) u_map (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	assign cmd_page = PW'(cmd_q.page_id);
	assign cmp_page = (state_q == ST_SCHK) ? scan_q : cmd_page;
	assign resident = used_q[m_rdata] && (owner_q[m_rdata] == cmp_page);
	assign pop_f    = fq_q[fhead_q];
	assign ul_n     = next_q[uf];
	assign ul_p     = prev_q[uf];
	assign ul_mid   = do_unlink && (ucnt_q > CW'(1)) && (uf != head_q) && (uf != tail_q);
	assign clearing = (state_q == ST_CLEAR);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == PW'(PAGE_IDS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					if (q_data.mode != MODE_FLUSH) state_d = ST_LOOK;
					else if (ucnt_q != '0) state_d = ST_SCAN;
				end
			end
			ST_LOOK: begin
				case (cmd_q.mode)
					MODE_ACCESS, MODE_PREALLOC: begin
						if (resident) state_d = ST_UNLINK;
						else if (fcnt_q == '0) state_d = ST_EVICT;
						else state_d = ST_ALLOC;
					end
					MODE_TOUCH: state_d = resident ? ST_UNLINK : ST_IDLE;
					MODE_ERASE, MODE_WBPAGE: state_d = resident ? ST_RELEASE : ST_IDLE;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_UNLINK:  state_d = ST_APPEND;
			ST_APPEND:  state_d = ST_IDLE;
			ST_EVICT:   state_d = ST_ALLOC;
			ST_ALLOC:   state_d = ST_APPEND;
			ST_RELEASE: state_d = ST_IDLE;
			ST_SCAN:    state_d = ST_SCHK;
			ST_SCHK: begin
				if (resident && ucnt_q == CW'(1)) state_d = ST_IDLE;
				else if (scan_q == PW'(PAGE_IDS - 1)) state_d = ST_IDLE;
				else state_d = ST_SCAN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control and result
	always_comb begin
		q_pop     = 1'b0;
		m_we      = 1'b0;
		m_waddr   = clr_q;
		m_wdata   = '0;
		m_raddr   = scan_q;
		uf        = tf_q;
		af        = tf_q;
		do_unlink = 1'b0;
		do_append = 1'b0;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		emit      = 1'b0;
		emit_rsp  = '0;
		emit_rsp.last = 1'b1;
		case (state_q)
			ST_CLEAR: m_we = 1'b1;
			ST_IDLE: begin
				q_pop   = q_valid;
				m_raddr = PW'(q_data.page_id);
				// flush with nothing resident
				emit    = q_valid && (q_data.mode == MODE_FLUSH) && (ucnt_q == '0);
			end
			ST_LOOK: begin
				if (!resident) begin
					if (cmd_q.mode == MODE_TOUCH) begin
						emit            = 1'b1;
						emit_rsp.status = 1'b1;
					end else if (cmd_q.mode == MODE_ERASE || cmd_q.mode == MODE_WBPAGE) begin
						emit = 1'b1;
					end
				end
			end
			ST_UNLINK: do_unlink = 1'b1;
			ST_APPEND: begin
				do_append      = 1'b1;
				emit           = 1'b1;
				emit_rsp.hit   = hit_q;
				emit_rsp.frame = 5'(tf_q);
				if (cmd_q.mode != MODE_TOUCH) begin
					emit_rsp.fill_from_storage = (cmd_q.mode == MODE_ACCESS) && !hit_q;
					emit_rsp.writeback         = wb_q;
					emit_rsp.writeback_page    = wb_q ? 10'(vp_q) : '0;
					emit_rsp.writeback_frame   = wb_q ? 5'(vf_q) : '0;
					emit_rsp.transfer_length   = cmd_q.xfer;
				end
			end
			ST_EVICT: begin
				uf        = head_q;
				do_unlink = 1'b1;
				do_push   = 1'b1;
			end
			ST_ALLOC: begin
				do_pop  = 1'b1;
				m_we    = 1'b1;
				m_waddr = cmd_page;
				m_wdata = pop_f;
			end
			ST_RELEASE: begin
				do_unlink      = 1'b1;
				do_push        = 1'b1;
				emit           = 1'b1;
				emit_rsp.hit   = 1'b1;
				emit_rsp.frame = 5'(tf_q);
				if (cmd_q.mode == MODE_WBPAGE) begin
					emit_rsp.writeback       = 1'b1;
					emit_rsp.writeback_page  = cmd_q.page_id;
					emit_rsp.writeback_frame = 5'(tf_q);
				end
			end
			ST_SCHK: begin
				uf = m_rdata;
				if (resident) begin
					do_unlink                = 1'b1;
					do_push                  = 1'b1;
					emit                     = 1'b1;
					emit_rsp.hit             = 1'b1;
					emit_rsp.frame           = 5'(m_rdata);
					emit_rsp.writeback       = 1'b1;
					emit_rsp.writeback_page  = 10'(scan_q);
					emit_rsp.writeback_frame = 5'(m_rdata);
					emit_rsp.last            = (ucnt_q == CW'(1));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			scan_q      <= '0;
			used_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			ucnt_q      <= '0;
			fhead_q     <= '0;
			ftail_q     <= '0;
			fcnt_q      <= CW'(FRAMES);
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < FRAMES; i++) begin
				fq_q[i] <= FW'(i);
			end
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= emit;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_IDLE) scan_q <= '0;
			else if (state_q == ST_SCHK) scan_q <= scan_q + 1'b1;
			if (do_unlink && ucnt_q != '0) begin
				if (ucnt_q != CW'(1)) begin
					if (uf == head_q) head_q <= ul_n;
					else if (uf == tail_q) tail_q <= ul_p;
				end
				ucnt_q <= ucnt_q - 1'b1;
			end
			if (do_append) begin
				if (ucnt_q == '0) head_q <= af;
				tail_q <= af;
				ucnt_q <= ucnt_q + 1'b1;
			end
			if (do_push) begin
				used_q[uf] <= 1'b0;
				if (fcnt_q < CW'(FRAMES)) begin
					fq_q[ftail_q] <= uf;
					ftail_q       <= (ftail_q == FW'(FRAMES - 1)) ? '0 : ftail_q + 1'b1;
					fcnt_q        <= fcnt_q + 1'b1;
				end
			end
			if (do_pop) begin
				used_q[pop_f] <= 1'b1;
				fhead_q       <= (fhead_q == FW'(FRAMES - 1)) ? '0 : fhead_q + 1'b1;
				fcnt_q        <= fcnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= emit_rsp;
		if (q_pop) cmd_q <= q_data;
		if (state_q == ST_LOOK) begin
			tf_q  <= m_rdata;
			hit_q <= resident;
			wb_q  <= 1'b0;
		end
		if (state_q == ST_EVICT) begin
			vf_q <= head_q;
			vp_q <= owner_q[head_q];
			wb_q <= 1'b1;
		end
		if (do_pop) begin
			tf_q           <= pop_f;
			owner_q[pop_f] <= cmd_page;
		end
		if (ul_mid) begin
			next_q[ul_p] <= ul_n;
			prev_q[ul_n] <= ul_p;
		end
		if (do_append && ucnt_q != '0) begin
			next_q[tail_q] <= af;
			prev_q[af]     <= tail_q;
		end
	end
endmodule
`default_nettype wire

// ----- src/lpfm_checker.sv -----
`default_nettype none
`include "lru_page_frame_manager_macros.svh"
module lpfm_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           rsp_valid,
	input wire lpfm_pkg::rsp_t rsp
);
	import lpfm_pkg::*;

	// not resident answers carry no hit
	`LPFM_ASSERT_IMP(a_status_no_hit, rsp_valid && rsp.status, !rsp.hit)
	// a fill from storage only follows a miss
	`LPFM_ASSERT_IMP(a_fill_miss, rsp_valid && rsp.fill_from_storage, !rsp.hit)
	// a resident write-back names the frame it frees
	`LPFM_ASSERT_IMP(a_wb_frame, rsp_valid && rsp.writeback && rsp.hit,
		rsp.frame == rsp.writeback_frame)
	`LPFM_ASSERT_IMP(a_wb_zero, rsp_valid && !rsp.writeback,
		rsp.writeback_page == '0 && rsp.writeback_frame == '0)
	// a beat that is not last is followed by more of the same flush, never back to back
	`LPFM_ASSERT_NEXT(a_flush_gap, rsp_valid && !rsp.last, !rsp_valid)
endmodule

bind lru_page_frame_manager lpfm_checker u_lpfm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp       (rsp)
);
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import lpfm_pkg::*;

	localparam int PAGES     = 1024;
	localparam int NFRAMES   = 32;
	localparam int WD_LIMIT  = 20000;
	localparam int CFG_QUIET = 24;
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	typedef struct {
		bit          is_cfg;
		req_t        r;
		logic [16:0] cv;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        rsp_valid;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = '0;

	lru_page_frame_manager u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.rsp_valid(rsp_valid), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the frame manager
	logic [16:0] page_size_sh;
	bit          map_valid [PAGES];
	logic [4:0]  map_frame [PAGES];
	logic [9:0]  owner [NFRAMES];
	logic [4:0]  lru_nx [NFRAMES];
	logic [4:0]  lru_pv [NFRAMES];
	logic [4:0]  lru_hd, lru_tl, fq_hd, fq_tl;
	int          used_n, free_n;
	logic [4:0]  free_fifo [NFRAMES];

	beat_t pending_q[$];
	rsp_t  expected_q[$];
	int    fails = 0, n_reqs = 0, n_rsps = 0, n_flush = 0, n_cfg = 0, n_evict = 0;
	int    quiet = 0, stall = 0;

	function void lru_remove(logic [4:0] f);
		if (used_n == 0) return;
		if (used_n == 1) begin
		end else if (f == lru_hd) begin
			lru_hd = lru_nx[f];
		end else if (f == lru_tl) begin
			lru_tl = lru_pv[f];
		end else begin
			lru_nx[lru_pv[f]] = lru_nx[f];
			lru_pv[lru_nx[f]] = lru_pv[f];
		end
		used_n--;
	endfunction

	function void lru_add(logic [4:0] f);
		if (used_n == 0) begin
			lru_hd = f;
		end else begin
			lru_nx[lru_tl] = f;
			lru_pv[f] = lru_tl;
		end
		lru_tl = f;
		used_n++;
	endfunction

	function void frame_release(logic [4:0] f);
		lru_remove(f);
		map_valid[owner[f]] = 1'b0;
		if (free_n < NFRAMES) begin
			free_fifo[fq_tl] = f;
			fq_tl = fq_tl + 5'd1;
			free_n++;
		end
	endfunction

	function void shadow_reset();
		page_size_sh = PAGE_SIZE_RST;
		for (int i = 0; i < PAGES; i++) map_valid[i] = 1'b0;
		for (int i = 0; i < NFRAMES; i++) free_fifo[i] = 5'(i);
		lru_hd = '0; lru_tl = '0; fq_hd = '0; fq_tl = '0;
		used_n = 0; free_n = NFRAMES;
	endfunction

	function void predict_frames(req_t r);
		rsp_t        o;
		logic [16:0] room, xfer;
		logic [4:0]  f;
		int          n;
		o = '0;
		o.last = 1'b1;
		room = (page_size_sh > 17'(r.offset)) ? page_size_sh - 17'(r.offset) : '0;
		xfer = (r.length < room) ? r.length : room;
		case (r.mode)
			MODE_ACCESS, MODE_PREALLOC: begin
				o.transfer_length = xfer;
				if (map_valid[r.page_id]) begin
					f = map_frame[r.page_id];
					lru_remove(f);
					lru_add(f);
					o.hit = 1'b1;
					o.frame = f;
				end else begin
					if (free_n == 0 && used_n > 0) begin
						o.writeback = 1'b1;
						o.writeback_frame = lru_hd;
						o.writeback_page = owner[lru_hd];
						n_evict++;
						frame_release(lru_hd);
					end
					f = free_fifo[fq_hd];
					fq_hd = fq_hd + 5'd1;
					free_n--;
					owner[f] = r.page_id;
					lru_add(f);
					map_valid[r.page_id] = 1'b1;
					map_frame[r.page_id] = f;
					o.frame = f;
					o.fill_from_storage = (r.mode == MODE_ACCESS);
				end
				expected_q.push_back(o);
			end
			MODE_TOUCH: begin
				if (map_valid[r.page_id]) begin
					f = map_frame[r.page_id];
					lru_remove(f);
					lru_add(f);
					o.hit = 1'b1;
					o.frame = f;
				end else begin
					o.status = 1'b1;
				end
				expected_q.push_back(o);
			end
			MODE_ERASE, MODE_WBPAGE: begin
				if (map_valid[r.page_id]) begin
					f = map_frame[r.page_id];
					frame_release(f);
					o.hit = 1'b1;
					o.frame = f;
					if (r.mode == MODE_WBPAGE) begin
						o.writeback = 1'b1;
						o.writeback_page = r.page_id;
						o.writeback_frame = f;
					end
				end
				expected_q.push_back(o);
			end
			MODE_FLUSH: begin
				n = 0;
				n_flush++;
				for (int p = 0; p < PAGES && n < NFRAMES; p++) begin
					if (map_valid[p]) begin
						f = map_frame[p];
						frame_release(f);
						map_valid[p] = 1'b0;
						o = '0;
						o.hit = 1'b1;
						o.frame = f;
						o.writeback = 1'b1;
						o.writeback_page = 10'(p);
						o.writeback_frame = f;
						expected_q.push_back(o);
						n++;
					end
				end
				if (n == 0) begin
					o = '0;
					o.last = 1'b1;
					expected_q.push_back(o);
				end else begin
					expected_q[$].last = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	function int draw_gap();
		if (stall > 0) begin
			stall--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) stall = $urandom_range(10, 30);
		return $urandom_range(0, 15);
	endfunction

	// driver: one beat at a time from pending_q
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		logic go_req, go_cfg;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			go_req = 1'b0;
			go_cfg = 1'b0;
			if (start && !busy) begin
				predict_frames(req);
				n_reqs++;
				void'(pending_q.pop_front());
				gap = draw_gap();
			end else if (cfg_valid && cfg_ready) begin
				page_size_sh = cfg_data;
				n_cfg++;
				void'(pending_q.pop_front());
				gap = draw_gap();
			end else if (start) begin
				go_req = 1'b1;
			end else if (cfg_valid) begin
				go_cfg = 1'b1;
			end
			if (!go_req && !go_cfg) begin
				if (gap > 0) begin
					gap--;
				end else if (pending_q.size() > 0) begin
					if (pending_q[0].is_cfg) begin
						// register writes only once the block has gone quiet
						if (expected_q.size() == 0 && !rsp_valid && quiet >= CFG_QUIET) begin
							go_cfg = 1'b1;
							cfg_data <= pending_q[0].cv;
						end
					end else begin
						go_req = 1'b1;
						req <= pending_q[0].r;
					end
				end
			end
			start <= go_req;
			cfg_valid <= go_cfg;
		end
	end

	// monitor and watchdog
	int wd = 0;
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (rsp_valid) begin
				n_rsps++;
				if (expected_q.size() == 0) begin
					$error("unexpected result beat frame=%0d", rsp.frame);
					fails++;
				end else begin
					e = expected_q.pop_front();
					if (rsp.status !== e.status) begin
						$error("status exp %0h got %0h", e.status, rsp.status); fails++;
					end
					if (rsp.hit !== e.hit) begin
						$error("hit exp %0h got %0h", e.hit, rsp.hit); fails++;
					end
					if (rsp.frame !== e.frame) begin
						$error("frame exp %0d got %0d", e.frame, rsp.frame); fails++;
					end
					if (rsp.fill_from_storage !== e.fill_from_storage) begin
						$error("fill_from_storage exp %0h got %0h",
							e.fill_from_storage, rsp.fill_from_storage);
						fails++;
					end
					if (rsp.writeback !== e.writeback) begin
						$error("writeback exp %0h got %0h", e.writeback, rsp.writeback); fails++;
					end
					if (rsp.writeback_page !== e.writeback_page) begin
						$error("writeback_page exp %0d got %0d",
							e.writeback_page, rsp.writeback_page);
						fails++;
					end
					if (rsp.writeback_frame !== e.writeback_frame) begin
						$error("writeback_frame exp %0d got %0d",
							e.writeback_frame, rsp.writeback_frame);
						fails++;
					end
					if (rsp.transfer_length !== e.transfer_length) begin
						$error("transfer_length exp %0d got %0d",
							e.transfer_length, rsp.transfer_length);
						fails++;
					end
					if (rsp.last !== e.last) begin
						$error("last exp %0h got %0h", e.last, rsp.last); fails++;
					end
				end
			end
			quiet <= (rsp_valid || (start && !busy)) ? 0 : quiet + 1;
			if (rsp_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
				wd = 0;
			end else begin
				wd++;
				if (wd >= WD_LIMIT) begin
					$display("watchdog expired with %0d results outstanding", expected_q.size());
					$display("** lru_page_frame_manager: FAILED **");
					$finish;
				end
			end
		end
	end

	function void add_req(logic [2:0] m, logic [9:0] p, logic [15:0] off, logic [16:0] len);
		beat_t b;
		b.is_cfg = 1'b0;
		b.cv = '0;
		b.r.mode = m;
		b.r.page_id = p;
		b.r.offset = off;
		b.r.length = len;
		pending_q.push_back(b);
	endfunction

	function void add_cfg(logic [16:0] v);
		beat_t b;
		b.is_cfg = 1'b1;
		b.r = '0;
		b.cv = v;
		pending_q.push_back(b);
	endfunction

	// a working set a bit larger than the frame count, so hits and evictions both happen
	function logic [9:0] pick_page();
		if ($urandom_range(0, 9) == 0) return 10'($urandom);
		return 10'($urandom_range(0, 47) * 21);
	endfunction

	function void add_random(int count);
		int  k;
		logic [2:0]  m;
		logic [15:0] off;
		logic [16:0] len;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 99);
			if (k < 55) m = ($urandom_range(0, 1) != 0) ? MODE_ACCESS : MODE_PREALLOC;
			else if (k < 72) m = MODE_TOUCH;
			else if (k < 82) m = MODE_ERASE;
			else if (k < 92) m = MODE_WBPAGE;
			else if (k < 96) m = MODE_FLUSH;
			else m = ($urandom_range(0, 1) != 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
			case ($urandom_range(0, 3))
				0: off = 16'($urandom);
				1: off = 16'($urandom_range(0, 64));
				default: off = 16'($urandom_range(0, 8191));
			endcase
			case ($urandom_range(0, 4))
				0: len = 17'($urandom_range(0, 65536));
				1: len = 17'd65536;
				default: len = 17'($urandom_range(0, 5000));
			endcase
			add_req(m, pick_page(), off, len);
		end
	endfunction

	initial begin
		shadow_reset();
		// directed: misses on an empty map, extremes, every mode
		add_req(MODE_TOUCH, 10'd5, 16'd0, 17'd0);
		add_req(MODE_ERASE, 10'd5, 16'd0, 17'd0);
		add_req(MODE_WBPAGE, 10'd5, 16'd0, 17'd0);
		add_req(MODE_FLUSH, 10'd0, 16'd0, 17'd0);
		add_req(MODE_ACCESS, 10'd0, 16'd0, 17'd0);
		add_req(MODE_ACCESS, 10'd1023, 16'hffff, 17'd65536);
		add_req(MODE_PREALLOC, 10'd5, 16'd100, 17'd65536);
		add_req(MODE_ACCESS, 10'd5, 16'd4095, 17'd1);
		add_req(MODE_ACCESS, 10'd1023, 16'd4096, 17'd10);
		add_req(MODE_TOUCH, 10'd0, 16'hffff, 17'h1ffff & 17'd65536);
		add_req(MODE_ERASE, 10'd5, 16'd0, 17'd0);
		add_req(MODE_WBPAGE, 10'd1023, 16'd0, 17'd0);
		add_req(MODE_SPARE_LO, 10'd3, 16'd0, 17'd0);
		add_req(MODE_SPARE_HI, 10'd4, 16'd0, 17'd0);
		add_req(MODE_PREALLOC, 10'd700, 16'h5555, 17'h0aaaa);
		add_req(MODE_ACCESS, 10'd341, 16'haaaa, 17'h15555);
		add_req(MODE_FLUSH, 10'd0, 16'd0, 17'd0);
		add_req(MODE_FLUSH, 10'd0, 16'd0, 17'd0);
		add_cfg(17'd1);
		add_req(MODE_ACCESS, 10'd9, 16'd0, 17'd65536);
		add_req(MODE_ACCESS, 10'd9, 16'd1, 17'd65536);
		add_random(45);
		add_cfg(17'd65536);
		add_req(MODE_ACCESS, 10'd9, 16'd0, 17'd65536);
		add_random(45);
		add_cfg(17'($urandom_range(1, 65536)));
		add_random(50);
		add_cfg(17'd4096);
		add_random(50);
		add_req(MODE_FLUSH, 10'd0, 16'd0, 17'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_q.size() == 0);
		wait (expected_q.size() == 0);
		repeat (40) @(posedge clk);
		$display("%0d requests, %0d result beats, %0d flushes, %0d evictions",
			n_reqs, n_rsps, n_flush, n_evict);
		$display("%0d page_size writes, %0d mismatches", n_cfg, fails);
		if (fails == 0 && expected_q.size() == 0) begin
			$display("** lru_page_frame_manager: PASSED **");
		end else begin
			$display("** lru_page_frame_manager: FAILED **");
		end
		$finish;
	end

endmodule
